// ===== hw/rtl/trace_record_framer_macros.svh =====
// Assertion macros for the trace record framer.
`ifndef TRACE_RECORD_FRAMER_MACROS_SVH
`define TRACE_RECORD_FRAMER_MACROS_SVH
`ifndef SYNTH
`define TRF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TRF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TRF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TRF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/trf_pkg.sv =====
// Shared types, codes and constants of the trace record framer.
package trf_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int CMD_BYTES = 6;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [1:0] KIND_BEGIN = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_FLAG      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MASK      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CKS_EN    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SEQ_EN    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_STAMP_LEN = 3'd5;

	localparam logic [7:0] FLAG_RESET   = 8'd126;
	localparam logic [7:0] ESCAPE_RESET = 8'd125;
	localparam logic [7:0] MASK_RESET   = 8'd32;
	localparam logic [2:0] STAMP_RESET  = 3'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] payload;
		logic [2:0]  payload_bytes;
		logic [31:0] stamp;
	} rec_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
	} stream_t;

	typedef struct packed {
		logic [7:0] flag_value;
		logic [7:0] escape_value;
		logic [7:0] escape_mask;
		logic       checksum_enable;
		logic       sequence_enable;
		logic [2:0] stamp_bytes;
	} cfg_t;

	// One classified record item: n stuffed bytes, then optionally the raw flag.
	typedef struct packed {
		logic                      clr;
		logic                      cks;
		logic                      tail;
		logic [2:0]                n;
		logic [CMD_BYTES-1:0][7:0] data;
	} cmd_t;

endpackage

// ===== hw/rtl/trf_front.sv =====
// Front end: accepts record items, numbers begin items and classifies them into commands.
module trf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  trf_pkg::cfg_t  cfg,
	input  logic           record_valid,
	output logic           record_ready,
	input  trf_pkg::rec_t  record,
	output logic           push,
	output trf_pkg::cmd_t  cmd,
	input  logic           q_full
);
	import trf_pkg::*;

	logic [7:0] seq_q;
	logic [2:0] stamp_n;
	logic [2:0] data_n;

	assign record_ready = !q_full;
	assign push = record_valid && record_ready;

	always_comb begin
		case (cfg.stamp_bytes)
			3'd0: stamp_n = 3'd0;
			3'd1: stamp_n = 3'd1;
			3'd4: stamp_n = 3'd4;
			default: stamp_n = 3'd2;
		endcase
	end

	// clamp data length to 1..4
	always_comb begin
		if (record.payload_bytes == 3'd0)
			data_n = 3'd1;
		else if (record.payload_bytes > 3'd4)
			data_n = 3'd4;
		else
			data_n = record.payload_bytes;
	end

	always_comb begin
		cmd = '0;
		case (record.kind)
			KIND_BEGIN: begin
				cmd.clr = 1'b1;
				if (cfg.sequence_enable) begin
					cmd.data = {record.stamp, seq_q, record.payload[7:0]};
					cmd.n = 3'(stamp_n + 3'd2);
				end else begin
					cmd.data = {8'h00, record.stamp, record.payload[7:0]};
					cmd.n = 3'(stamp_n + 3'd1);
				end
			end
			KIND_DATA: begin
				cmd.data = {16'h0000, record.payload};
				cmd.n = data_n;
			end
			KIND_END: begin
				cmd.cks = cfg.checksum_enable;
				cmd.tail = 1'b1;
				cmd.n = {2'b00, cfg.checksum_enable};
			end
			default: begin
				cmd.clr = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
		end else if (push && record.kind == KIND_BEGIN && cfg.sequence_enable) begin
			seq_q <= 8'(seq_q + 8'd1);
		end
	end

endmodule

// ===== hw/rtl/trf_queue.sv =====
// Command queue between the front end and the byte emitter.
module trf_queue #(
	parameter int DEPTH = trf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  trf_pkg::cmd_t wr_cmd,
	input  logic          pop,
	output trf_pkg::cmd_t head,
	output logic          full,
	output logic          empty
);
	import trf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full = count_q == FULL_CNT;
	assign empty = count_q == '0;
	assign head = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			if (do_push && !do_pop)
				count_q <= CNT_W'(count_q + 1'b1);
			else if (do_pop && !do_push)
				count_q <= CNT_W'(count_q - 1'b1);
		end
	end

endmodule

// ===== hw/rtl/trf_back.sv =====
// Back end: expands commands into stuffed stream bytes and keeps the running sum.
module trf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  trf_pkg::cfg_t    cfg,
	input  trf_pkg::cmd_t    head,
	input  logic             empty,
	output logic             pop,
	output logic             stream_valid,
	input  logic             stream_ready,
	output trf_pkg::stream_t stream
);
	import trf_pkg::*;

	logic [2:0] idx_q;
	logic       esc_pend_q;
	logic [7:0] esc_byte_q;
	logic [7:0] sum_q;
	logic       valid_q;
	stream_t    out_q;

	logic       slot_free;
	logic       in_tail;
	logic       last_byte;
	logic [7:0] sum_base;
	logic [7:0] cur;
	logic       needs_esc;
	logic       emit;
	logic       add_sum;
	logic       step;
	logic       set_pend;
	logic       skip;
	stream_t    nxt;

	assign slot_free = !valid_q || stream_ready;
	assign in_tail = idx_q == head.n;
	assign last_byte = (3'(idx_q + 3'd1) == head.n) && !head.tail;
	assign sum_base = (head.clr && idx_q == 3'd0) ? 8'h00 : sum_q;

	always_comb begin
		if (head.cks)
			cur = 8'(8'h00 - sum_base);
		else if (idx_q < 3'(CMD_BYTES))
			cur = head.data[idx_q];
		else
			cur = 8'h00;
	end

	assign needs_esc = cur == cfg.flag_value || cur == cfg.escape_value;

	always_comb begin
		emit = 1'b0;
		add_sum = 1'b0;
		step = 1'b0;
		set_pend = 1'b0;
		skip = 1'b0;
		nxt = '0;
		if (!empty) begin
			if (head.n == 3'd0 && !head.tail) begin
				// clear item: no bytes, drop it and reset the running sum
				skip = 1'b1;
			end else if (slot_free) begin
				emit = 1'b1;
				if (esc_pend_q) begin
					nxt.out_byte = esc_byte_q;
					nxt.run_end = last_byte;
					step = 1'b1;
				end else if (in_tail) begin
					nxt.out_byte = cfg.flag_value;
					nxt.run_end = 1'b1;
				end else if (needs_esc) begin
					nxt.out_byte = cfg.escape_value;
					nxt.run_end = 1'b0;
					set_pend = 1'b1;
					add_sum = 1'b1;
				end else begin
					nxt.out_byte = cur;
					nxt.run_end = last_byte;
					step = 1'b1;
					add_sum = 1'b1;
				end
			end
		end
	end

	assign pop = skip || (emit && nxt.run_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			esc_pend_q <= 1'b0;
			sum_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (skip)
				sum_q <= 8'h00;
			else if (add_sum)
				sum_q <= 8'(sum_base + cur);
			if (set_pend)
				esc_pend_q <= 1'b1;
			else if (step)
				esc_pend_q <= 1'b0;
			if (pop)
				idx_q <= '0;
			else if (step)
				idx_q <= 3'(idx_q + 3'd1);
			if (emit)
				valid_q <= 1'b1;
			else if (stream_ready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (set_pend)
			esc_byte_q <= cur ^ cfg.escape_mask;
		if (emit)
			out_q <= nxt;
	end

	assign stream_valid = valid_q;
	assign stream = out_q;

endmodule

// ===== hw/rtl/trace_record_framer.sv =====
// Top level of the trace record framer: registers, front end, queue and byte emitter.
//
// Record items enter on record_valid/record_ready/record; each beat is a begin,
// data, end or clear item. Framed bytes leave on stream_valid/stream_ready/stream,
// one byte per beat, with run_end set on the last byte caused by an item.
// Registers are written through cfg_we/cfg_index/cfg_data, with no wait.
//
// An item is classified in the cycle it is accepted and queued; the byte emitter
// takes it from the queue head and the output byte is registered. The emitter
// puts out one byte per cycle while the receiver takes them: an escaped byte
// goes out as two bytes, and a clear item is dropped with no byte. Record beats
// are taken every cycle while the queue of QUEUE_DEPTH commands has room.
//
// Reset clears the queue, the running sum and the sequence number and loads the
// register defaults. When the receiver stalls, the output byte holds, the emitter
// stops and the queue fills; record_ready drops once it is full.
module trace_record_framer #(
	parameter int QUEUE_DEPTH = trf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [trf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [trf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                record_valid,
	output logic                                record_ready,
	input  trf_pkg::rec_t                       record,
	output logic                                stream_valid,
	input  logic                                stream_ready,
	output trf_pkg::stream_t                    stream
);
	import trf_pkg::*;
	`include "trace_record_framer_macros.svh"

	cfg_t cfg_q;
	cmd_t front_cmd;
	cmd_t head;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_value <= FLAG_RESET;
			cfg_q.escape_value <= ESCAPE_RESET;
			cfg_q.escape_mask <= MASK_RESET;
			cfg_q.checksum_enable <= 1'b1;
			cfg_q.sequence_enable <= 1'b1;
			cfg_q.stamp_bytes <= STAMP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FLAG:      cfg_q.flag_value <= cfg_data;
				REG_ESCAPE:    cfg_q.escape_value <= cfg_data;
				REG_MASK:      cfg_q.escape_mask <= cfg_data;
				REG_CKS_EN:    cfg_q.checksum_enable <= cfg_data[0];
				REG_SEQ_EN:    cfg_q.sequence_enable <= cfg_data[0];
				REG_STAMP_LEN: cfg_q.stamp_bytes <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	trf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.record_valid (record_valid),
		.record_ready (record_ready),
		.record       (record),
		.push         (push),
		.cmd          (front_cmd),
		.q_full       (q_full)
	);

	trf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (front_cmd),
		.pop    (pop),
		.head   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	trf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.empty        (q_empty),
		.pop          (pop),
		.stream_valid (stream_valid),
		.stream_ready (stream_ready),
		.stream       (stream)
	);

	// an escape prefix beat is always followed at once by the escaped byte
	`TRF_ASSERT_NXT(a_esc_follows, clk, arst_n, stream_valid && stream_ready && !stream.run_end && stream.out_byte == cfg_q.escape_value && !cfg_we, stream_valid, "escape prefix not followed by a byte")
	// a stalled front end means the queue holds work
	`TRF_ASSERT_IMP(a_full_not_empty, clk, arst_n, !record_ready, !q_empty, "queue full and empty at once")
	// nothing leaves the emitter without a queued command behind it
	`TRF_ASSERT_IMP(a_pop_has_cmd, clk, arst_n, pop, !q_empty, "pop from empty queue")

endmodule

// ===== tb/trace_record_framer_tb.sv =====
// Self-checking testbench for the trace record framer: directed table, then random records.
`timescale 1ns / 100ps

module trace_record_framer_tb;
	import trf_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int REPORT_CAP  = 30;

	logic                   clk;
	logic                   arst_n       = 1'b0;
	logic                   cfg_we       = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;
	logic                   record_valid = 1'b0;
	logic                   record_ready;
	rec_t                   record       = '0;
	logic                   stream_valid;
	logic                   stream_ready = 1'b0;
	stream_t                stream;

	trace_record_framer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.record_valid (record_valid),
		.record_ready (record_ready),
		.record       (record),
		.stream_valid (stream_valid),
		.stream_ready (stream_ready),
		.stream       (stream)
	);

	typedef struct {
		bit                     is_reg;
		logic [CFG_INDEX_W-1:0] reg_idx;
		logic [7:0]             reg_val;
		rec_t                   rec;
		int                     fixed_len;
		logic [95:0]            fixed;
	} step_t;

	// Framer state as the testbench sees it
	cfg_t       regs_shadow = '{FLAG_RESET, ESCAPE_RESET, MASK_RESET, 1'b1, 1'b1, STAMP_RESET};
	logic [7:0] sum_acc     = '0;
	logic [7:0] seq_num     = '0;

	stream_t frame_buf[$];
	stream_t expected_bytes[$];
	step_t   directed[$];

	// Typed-in expectation that travels with the record beat; -1 means use the predictor
	int          fixed_len   = -1;
	logic [95:0] fixed_bytes = '0;

	bit steady_send    = 1'b0;
	int err_count      = 0;
	int items_sent     = 0;
	int bytes_checked  = 0;
	int records_closed = 0;
	int cycle_count    = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Favor the flag and escape codes so stuffing happens often
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return regs_shadow.flag_value;
		else if (r < 4)
			return regs_shadow.escape_value;
		return 8'($urandom);
	endfunction

	function automatic void emit_raw(logic [7:0] b);
		stream_t s;
		s.out_byte = b;
		s.run_end  = 1'b0;
		frame_buf.push_back(s);
	endfunction

	function automatic void stuff_byte(logic [7:0] b);
		sum_acc = sum_acc + b;
		if (b == regs_shadow.flag_value || b == regs_shadow.escape_value) begin
			emit_raw(regs_shadow.escape_value);
			emit_raw(b ^ regs_shadow.escape_mask);
		end else
			emit_raw(b);
	endfunction

	function automatic void frame_record(rec_t r);
		int         n;
		logic [7:0] ck;
		frame_buf.delete();
		case (r.kind)
			KIND_BEGIN: begin
				sum_acc = '0;
				stuff_byte(r.payload[7:0]);
				if (regs_shadow.sequence_enable) begin
					stuff_byte(seq_num);
					seq_num = seq_num + 8'd1;
				end
				case (regs_shadow.stamp_bytes)
					3'd0: n = 0;
					3'd1: n = 1;
					3'd4: n = 4;
					default: n = 2;
				endcase
				for (int i = 0; i < n; i++)
					stuff_byte(r.stamp[8*i +: 8]);
			end
			KIND_DATA: begin
				if (r.payload_bytes == 3'd0)
					n = 1;
				else if (r.payload_bytes > 3'd4)
					n = 4;
				else
					n = int'(r.payload_bytes);
				for (int i = 0; i < n; i++)
					stuff_byte(r.payload[8*i +: 8]);
			end
			KIND_END: begin
				if (regs_shadow.checksum_enable) begin
					ck = 8'h00 - sum_acc;
					stuff_byte(ck);
				end
				emit_raw(regs_shadow.flag_value);
			end
			default: sum_acc = '0;
		endcase
		if (frame_buf.size() > 0)
			frame_buf[frame_buf.size()-1].run_end = 1'b1;
	endfunction

	task automatic report_mismatch(string msg);
		if (err_count < REPORT_CAP)
			$display("[%0t] mismatch: %s", $time, msg);
		err_count++;
	endtask

	// Predict on record beats, check on stream beats
	always @(posedge clk) begin
		stream_t want;
		if (arst_n && record_valid && record_ready) begin
			frame_record(record);
			if (record.kind == KIND_END)
				records_closed++;
			if (fixed_len >= 0) begin
				for (int i = 0; i < fixed_len; i++) begin
					want.out_byte = fixed_bytes[(fixed_len-1-i)*8 +: 8];
					want.run_end  = (i == fixed_len - 1);
					expected_bytes.push_back(want);
				end
			end else
				foreach (frame_buf[i])
					expected_bytes.push_back(frame_buf[i]);
		end
		if (arst_n && stream_valid && stream_ready) begin
			if (expected_bytes.size() == 0)
				report_mismatch($sformatf("unexpected byte %02h run_end %0b",
					stream.out_byte, stream.run_end));
			else begin
				want = expected_bytes.pop_front();
				if (stream.out_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte %02h, want %02h",
						stream.out_byte, want.out_byte));
				if (stream.run_end !== want.run_end)
					report_mismatch($sformatf("run_end %0b on byte %02h, want %0b",
						stream.run_end, stream.out_byte, want.run_end));
				bytes_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes outstanding",
				cycle_count, expected_bytes.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: bursts of ready with stalls of random length, now and then a long clean run
	initial begin
		int hold;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stream_ready <= 1'b1;
			if ($urandom_range(0, 9) == 0)
				hold = $urandom_range(100, 200);
			else
				hold = $urandom_range(1, 30);
			repeat (hold) @(posedge clk);
			hold = pick_gap();
			if (hold > 0) begin
				stream_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
		end
	end

	// Call at a clock edge; returns at the edge that takes the beat
	task automatic send_record(rec_t r, int len = -1, logic [95:0] bytes = '0);
		int gap;
		gap = steady_send ? 0 : pick_gap();
		if (gap > 0) begin
			record_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		record_valid <= 1'b1;
		record       <= r;
		fixed_len    <= len;
		fixed_bytes  <= bytes;
		@(posedge clk);
		while (!record_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Hold off until every expected byte is out, then let a trailing clear item retire
	task automatic wait_idle();
		record_valid <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Leaves cfg_we high; the caller drops it
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		case (idx)
			REG_FLAG:      regs_shadow.flag_value      = v;
			REG_ESCAPE:    regs_shadow.escape_value    = v;
			REG_MASK:      regs_shadow.escape_mask     = v;
			REG_CKS_EN:    regs_shadow.checksum_enable = v[0];
			REG_SEQ_EN:    regs_shadow.sequence_enable = v[0];
			REG_STAMP_LEN: regs_shadow.stamp_bytes     = v[2:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_config(logic [7:0] flag, logic [7:0] esc, logic [7:0] mask,
			logic [7:0] cks, logic [7:0] seq, logic [7:0] stamp_len);
		wait_idle();
		write_reg(REG_FLAG, flag);
		write_reg(REG_ESCAPE, esc);
		write_reg(REG_MASK, mask);
		write_reg(REG_CKS_EN, cks);
		write_reg(REG_SEQ_EN, seq);
		write_reg(REG_STAMP_LEN, stamp_len);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic step_t rec_row(logic [1:0] kind, logic [31:0] payload, logic [2:0] pb,
			logic [31:0] stamp, int len = -1, logic [95:0] bytes = '0);
		step_t s;
		s.is_reg    = 1'b0;
		s.reg_idx   = '0;
		s.reg_val   = '0;
		s.rec       = '{kind, payload, pb, stamp};
		s.fixed_len = len;
		s.fixed     = bytes;
		return s;
	endfunction

	function automatic step_t reg_row(logic [CFG_INDEX_W-1:0] idx, logic [7:0] v);
		step_t s;
		s           = rec_row(KIND_CLEAR, '0, '0, '0);
		s.is_reg    = 1'b1;
		s.reg_idx   = idx;
		s.reg_val   = v;
		return s;
	endfunction

	function automatic rec_t make_rec(logic [1:0] kind);
		rec_t r;
		r.kind    = kind;
		r.payload = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
		r.stamp   = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
		if ($urandom_range(0, 6) == 0)
			r.payload_bytes = 3'($urandom_range(0, 7));
		else
			r.payload_bytes = 3'($urandom_range(1, 4));
		return r;
	endfunction

	// Mostly whole records with random content, plus stray and clear items
	task automatic random_unit();
		int r;
		int k;
		r = $urandom_range(0, 9);
		steady_send = ($urandom_range(0, 3) == 0);
		if (r <= 6) begin
			send_record(make_rec(KIND_BEGIN));
			k = $urandom_range(0, 4);
			repeat (k) send_record(make_rec(KIND_DATA));
			if ($urandom_range(0, 9) == 0)
				send_record(make_rec(KIND_CLEAR));
			send_record(make_rec(KIND_END));
		end else if (r == 7)
			send_record(make_rec(KIND_CLEAR));
		else
			send_record(make_rec(2'($urandom_range(0, 3))));
	endtask

	initial begin
		int         phase_start;
		int         n_directed;
		logic [7:0] same;

		// Defaults after reset: flag 7e, escape 7d, mask 20, checksum and sequence on, 2-byte stamp
		directed.push_back(rec_row(KIND_BEGIN, 32'h0, 3'd1, 32'h0,
			4, {8'h00, 8'h00, 8'h00, 8'h00}));
		directed.push_back(rec_row(KIND_DATA, 32'h0000_7d7e, 3'd2, 32'h0,
			4, {8'h7d, 8'h5e, 8'h7d, 8'h5d}));
		directed.push_back(rec_row(KIND_END, 32'h0, 3'd1, 32'h0, 2, {8'h05, 8'h7e}));
		directed.push_back(rec_row(KIND_BEGIN, 32'hffff_ffff, 3'd7, 32'hffff_ffff,
			4, {8'hff, 8'h01, 8'hff, 8'hff}));
		// Zero length reads as one byte, lengths above four as four
		directed.push_back(rec_row(KIND_DATA, 32'h1234_5678, 3'd0, 32'h0, 1, {8'h78}));
		directed.push_back(rec_row(KIND_DATA, 32'hffff_ffff, 3'd7, 32'hffff_ffff,
			4, {8'hff, 8'hff, 8'hff, 8'hff}));
		directed.push_back(rec_row(KIND_CLEAR, 32'hffff_ffff, 3'd7, 32'hffff_ffff, 0));
		directed.push_back(rec_row(KIND_END, 32'h0, 3'd1, 32'h0, 2, {8'h00, 8'h7e}));
		directed.push_back(rec_row(KIND_DATA, 32'h7d7e_7d7e, 3'd4, 32'h0));
		directed.push_back(rec_row(KIND_DATA, 32'ha5a5_0f0f, 3'd5, 32'h0));
		directed.push_back(rec_row(KIND_END, 32'h0, 3'd1, 32'h0));
		// Every stamp size, the odd ones falling back to two bytes
		directed.push_back(reg_row(REG_STAMP_LEN, 8'd4));
		directed.push_back(rec_row(KIND_BEGIN, 32'h0000_007e, 3'd1, 32'h7e7d_7e7d));
		directed.push_back(reg_row(REG_STAMP_LEN, 8'd1));
		directed.push_back(rec_row(KIND_BEGIN, 32'h0000_0001, 3'd1, 32'h0000_00aa));
		directed.push_back(reg_row(REG_STAMP_LEN, 8'd0));
		directed.push_back(rec_row(KIND_BEGIN, 32'h0000_0002, 3'd1, 32'hdead_beef));
		directed.push_back(reg_row(REG_STAMP_LEN, 8'd3));
		directed.push_back(rec_row(KIND_BEGIN, 32'h0000_0003, 3'd1, 32'h0102_0304));
		directed.push_back(reg_row(REG_STAMP_LEN, 8'd7));
		directed.push_back(rec_row(KIND_BEGIN, 32'h0000_0004, 3'd1, 32'h0506_7e7d));
		directed.push_back(reg_row(REG_STAMP_LEN, 8'd5));
		directed.push_back(rec_row(KIND_BEGIN, 32'h0000_0005, 3'd1, 32'h1122_3344));
		directed.push_back(reg_row(REG_STAMP_LEN, 8'd6));
		directed.push_back(rec_row(KIND_BEGIN, 32'h0000_0006, 3'd1, 32'h5566_7788));
		// Sequence off leaves the counter alone
		directed.push_back(reg_row(REG_SEQ_EN, 8'd0));
		directed.push_back(rec_row(KIND_BEGIN, 32'h0000_0007, 3'd1, 32'h99aa_bbcc));
		directed.push_back(rec_row(KIND_END, 32'h0, 3'd1, 32'h0));
		// Checksum off: end is the raw flag only
		directed.push_back(reg_row(REG_CKS_EN, 8'd0));
		directed.push_back(rec_row(KIND_DATA, 32'h0000_7e00, 3'd2, 32'h0));
		directed.push_back(rec_row(KIND_END, 32'h0, 3'd1, 32'h0));
		// Flag equal to escape: both escape alike, the closing flag stays raw
		directed.push_back(reg_row(REG_FLAG, 8'h55));
		directed.push_back(reg_row(REG_ESCAPE, 8'h55));
		directed.push_back(reg_row(REG_MASK, 8'haa));
		directed.push_back(reg_row(REG_CKS_EN, 8'd1));
		directed.push_back(rec_row(KIND_BEGIN, 32'h0000_0055, 3'd1, 32'h0055_5500));
		directed.push_back(rec_row(KIND_DATA, 32'h5555_5555, 3'd3, 32'h0));
		directed.push_back(rec_row(KIND_END, 32'h0, 3'd1, 32'h0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_reg) begin
				wait_idle();
				write_reg(directed[i].reg_idx, directed[i].reg_val);
				cfg_we <= 1'b0;
				@(posedge clk);
			end else
				send_record(directed[i].rec, directed[i].fixed_len, directed[i].fixed);
		end
		n_directed = items_sent;

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: load_config(8'h7e, 8'h7d, 8'h20, 8'd1, 8'd1, 8'd4);
				1: load_config(8'h00, 8'hff, 8'hff, 8'd0, 8'd0, 8'd0);
				2: load_config(8'hff, 8'h00, 8'h00, 8'hff, 8'hfe, 8'hf9);
				3: begin
					same = 8'($urandom);
					load_config(same, same, 8'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom));
				end
				default: load_config(8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			phase_start = items_sent;
			while (items_sent - phase_start < 40)
				random_unit();
		end
		steady_send = 1'b0;

		record_valid <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		$display("Sent %0d record items (%0d from the directed table),",
			items_sent, n_directed);
		$display("checked %0d bytes in %0d records over default, stamp, flag and random codes.",
			bytes_checked, records_closed);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
